[sv/sts_pkg.sv]
package sts_pkg;

    localparam int MAX_WORD_LEN_DEF = 32;
    localparam int POS_BITS_DEF     = 16;

    localparam int LEN_W  = 6;
    localparam int KW_NUM = 19;
    localparam int VAL_W  = 31;

    typedef enum logic [3:0] {
        M_IDLE, M_ZERO, M_HEXX, M_HEX, M_DEC, M_WORD, M_EQ, M_LT, M_GT, M_BANG
    } mode_t;

    typedef enum logic [2:0] {
        C_IDLE, C_EVAL, C_FLUSH, C_WPREP, C_WOUT, C_AFTER, C_START, C_HALT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic eval;
        logic flush;
        logic word_start;
        logic word_emit;
        logic start;
        logic end_emit;
    } cmd_t;

    typedef struct packed {
        logic eoi;
        logic used;
        logic eval_emit;
        logic eval_fail;
        logic flush_word;
        logic flush_emit;
        logic flush_fail;
        logic start_emit;
        logic start_fail;
        logic word_last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [5:0]       ttype;
        logic [VAL_W-1:0] value;
        logic [2:0]       err;
        logic             last;
    } res_t;

    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [2:0] ERR_INVALID   = 3'd0;
    localparam logic [2:0] ERR_LEADZERO  = 3'd1;
    localparam logic [2:0] ERR_BADHEX    = 3'd2;
    localparam logic [2:0] ERR_DIGIT_LED = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

    localparam logic [5:0] TT_IDENT = 6'd0;
    localparam logic [5:0] TT_INT   = 6'd1;
    localparam logic [5:0] TT_PLUS  = 6'd16;
    localparam logic [5:0] TT_MINUS = 6'd17;
    localparam logic [5:0] TT_STAR  = 6'd18;
    localparam logic [5:0] TT_SLASH = 6'd19;
    localparam logic [5:0] TT_ASSIGN = 6'd20;
    localparam logic [5:0] TT_EQEQ  = 6'd21;
    localparam logic [5:0] TT_SEMI  = 6'd22;
    localparam logic [5:0] TT_LPAR  = 6'd23;
    localparam logic [5:0] TT_RPAR  = 6'd24;
    localparam logic [5:0] TT_LT    = 6'd25;
    localparam logic [5:0] TT_LE    = 6'd26;
    localparam logic [5:0] TT_GT    = 6'd27;
    localparam logic [5:0] TT_GE    = 6'd28;
    localparam logic [5:0] TT_LBRACE = 6'd29;
    localparam logic [5:0] TT_RBRACE = 6'd30;
    localparam logic [5:0] TT_LBRACK = 6'd31;
    localparam logic [5:0] TT_RBRACK = 6'd32;
    localparam logic [5:0] TT_BANG  = 6'd33;
    localparam logic [5:0] TT_NE    = 6'd34;
    localparam logic [5:0] TT_COMMA = 6'd35;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_BANG  = "!";

    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        64'("scan"), 64'("void"), 64'("int"), 64'("char"), 64'("double"),
        64'("struct"), 64'("if"), 64'("else"), 64'("switch"), 64'("case"),
        64'("default"), 64'("while"), 64'("for"), 64'("do"), 64'("return"),
        64'("break"), 64'("continue"), 64'("const"), 64'("print")
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd4, 4'd4, 4'd3, 4'd4, 4'd6, 4'd6, 4'd2, 4'd4, 4'd6, 4'd4,
        4'd7, 4'd5, 4'd3, 4'd2, 4'd6, 4'd5, 4'd8, 4'd5, 4'd5
    };
    localparam logic [5:0] KW_CLS [KW_NUM] = '{
        6'd2, 6'd3, 6'd3, 6'd3, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd7,
        6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15
    };

    // character p of keyword k, p below its length
    function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] p);
        logic [2:0]  sel;
        logic [63:0] w;
        sel = 3'(KW_LEN[k] - 4'd1 - {1'b0, p});
        w   = KW_TEXT[k] >> {sel, 3'b000};
        return w[7:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == CH_SPACE;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (is_digit(c))
            v = c - 8'd48;
        else if (c >= "a")
            v = c - 8'd87;
        else
            v = c - 8'd55;
        return v[3:0];
    endfunction

endpackage

[sv/sts_ctrl.sv]
module sts_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sts_pkg::status_t st,
    output sts_pkg::cmd_t    cmd
);
    import sts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = C_EVAL;
                end
            end
            C_EVAL:
            begin
                if (st.eoi || !st.used)
                    state_next = C_FLUSH;
                else if (!st.eval_emit)
                begin
                    cmd.eval   = 1'b1;
                    state_next = C_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.eval   = 1'b1;
                    state_next = st.eval_fail ? C_HALT : C_IDLE;
                end
            end
            C_FLUSH:
            begin
                if (st.flush_word)
                begin
                    cmd.word_start = 1'b1;
                    state_next     = C_WPREP;
                end
                else if (!st.flush_emit)
                    state_next = C_AFTER;
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = st.flush_fail ? C_HALT : C_AFTER;
                end
            end
            C_WPREP:
                state_next = C_WOUT;
            C_WOUT:
            begin
                if (st.out_free)
                begin
                    cmd.word_emit = 1'b1;
                    state_next    = st.word_last ? C_AFTER : C_WPREP;
                end
            end
            C_AFTER:
            begin
                if (!st.eoi)
                    state_next = C_START;
                else if (st.out_free)
                begin
                    cmd.end_emit = 1'b1;
                    state_next   = C_HALT;
                end
            end
            C_START:
            begin
                if (!st.start_emit)
                begin
                    cmd.start  = 1'b1;
                    state_next = C_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.start  = 1'b1;
                    state_next = st.start_fail ? C_HALT : C_IDLE;
                end
            end
            C_HALT:
                in_ready = 1'b1;
            default:
                state_next = C_IDLE;
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("more than one datapath command");
    a_halt_stays: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_HALT |=> state_reg == C_HALT)
        else $error("left halt state");
    a_ready_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == C_IDLE || state_reg == C_HALT))
        else $error("ready outside idle or halt");

endmodule

[sv/sts_datapath.sv]
module sts_datapath #(
    parameter int MAX_WORD_LEN = sts_pkg::MAX_WORD_LEN_DEF,
    parameter int POS_BITS     = sts_pkg::POS_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sts_pkg::cmd_t         cmd,
    output sts_pkg::status_t      st,
    input  logic [7:0]            in_byte,
    input  logic                  in_eoi,
    input  logic                  out_ready,
    output logic                  out_valid,
    output sts_pkg::res_t         out_res,
    output logic [POS_BITS-1:0]   out_line,
    output logic [POS_BITS-1:0]   out_col
);
    import sts_pkg::*;

    localparam int IDX_W = $clog2(MAX_WORD_LEN);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_LEN);
    localparam logic [VAL_W-1:0] NUM_MAX = '1;

    mode_t               mode_reg, mode_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                dl_reg, dl_next;
    logic [VAL_W-1:0]    acc_reg, acc_next;
    logic [POS_BITS-1:0] tok_line_reg, tok_line_next, tok_col_reg, tok_col_next;
    logic [POS_BITS-1:0] cur_line_reg, cur_line_next, cur_col_reg, cur_col_next;
    logic [POS_BITS-1:0] lat_line_reg, lat_col_reg;
    logic [7:0]          byte_reg;
    logic                eoi_reg;
    logic [KW_NUM-1:0]   cand_reg, cand_next;
    logic [LEN_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [7:0]          mem [MAX_WORD_LEN];
    logic [7:0]          mem_q_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;
    logic [POS_BITS-1:0] out_line_reg, out_col_reg;

    logic [7:0]          c;
    logic                c_dig, c_alp, c_hex, at_max;
    logic [34:0]         acc_prod, acc_sum;
    logic [VAL_W-1:0]    acc_sat;
    logic                ev_used, ev_emit, ev_fail, ev_bump, ev_acc, ev_base16, ev_wadd;
    mode_t               ev_mode;
    res_t                ev_res;
    logic                fl_word, fl_emit, fl_fail;
    res_t                fl_res;
    logic                stt_emit, stt_fail;
    mode_t               stt_mode;
    res_t                stt_res, wd_res;
    logic [5:0]          word_cls;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                emit;
    res_t                emit_res;
    logic [POS_BITS-1:0] emit_line, emit_col;
    logic                word_last;

    assign c      = byte_reg;
    assign c_dig  = is_digit(c);
    assign c_alp  = is_alpha(c);
    assign c_hex  = c_dig || is_hex_letter(c);
    assign at_max = len_reg >= LEN_MAX;

    assign acc_prod = ev_base16 ? 35'({acc_reg, 4'b0000})
                                : 35'({acc_reg, 3'b000}) + 35'({acc_reg, 1'b0});
    assign acc_sum  = acc_prod + 35'(hex_value(c));
    assign acc_sat  = (acc_sum[34:VAL_W] != '0) ? NUM_MAX : acc_sum[VAL_W-1:0];

    // byte in the current mode
    always_comb
    begin
        ev_used   = 1'b0;
        ev_emit   = 1'b0;
        ev_fail   = 1'b0;
        ev_bump   = 1'b0;
        ev_acc    = 1'b0;
        ev_base16 = 1'b0;
        ev_wadd   = 1'b0;
        ev_mode   = mode_reg;
        ev_res    = '{kind: KIND_TOKEN, ttype: TT_IDENT, value: '0, err: ERR_INVALID,
                      last: 1'b1};
        case (mode_reg)
            M_ZERO:
            begin
                if (c == "x" || c == "X")
                begin
                    ev_used = 1'b1;
                    ev_mode = M_HEXX;
                    ev_bump = 1'b1;
                end
                else if (c_dig)
                begin
                    ev_used = 1'b1;
                    ev_fail = 1'b1;
                    ev_res.err = ERR_LEADZERO;
                end
                else if (c_alp)
                    ev_wadd = 1'b1;
            end
            M_HEXX:
            begin
                if (c_hex)
                begin
                    ev_used   = 1'b1;
                    ev_mode   = M_HEX;
                    ev_bump   = 1'b1;
                    ev_acc    = 1'b1;
                    ev_base16 = 1'b1;
                end
                else if (c_alp)
                    ev_wadd = 1'b1;
                else
                begin
                    ev_used = 1'b1;
                    ev_fail = 1'b1;
                    ev_res.err = ERR_BADHEX;
                end
            end
            M_HEX:
            begin
                if (c_hex)
                begin
                    ev_used   = 1'b1;
                    ev_bump   = 1'b1;
                    ev_acc    = 1'b1;
                    ev_base16 = 1'b1;
                end
                else if (c_alp)
                    ev_wadd = 1'b1;
            end
            M_DEC:
            begin
                if (c_dig)
                begin
                    ev_used = 1'b1;
                    ev_bump = 1'b1;
                    ev_acc  = 1'b1;
                end
                else if (c_alp)
                    ev_wadd = 1'b1;
            end
            M_WORD:
            begin
                if (c_dig || c_alp)
                    ev_wadd = 1'b1;
            end
            M_EQ, M_LT, M_GT, M_BANG:
            begin
                if (c == CH_EQ)
                begin
                    ev_used = 1'b1;
                    ev_emit = 1'b1;
                    ev_mode = M_IDLE;
                    case (mode_reg)
                        M_EQ:    begin ev_res.ttype = TT_EQEQ; ev_res.value = VAL_W'(CH_EQ); end
                        M_LT:    begin ev_res.ttype = TT_LE; ev_res.value = VAL_W'(CH_LT); end
                        M_GT:    begin ev_res.ttype = TT_GE; ev_res.value = VAL_W'(CH_GT); end
                        default: begin ev_res.ttype = TT_NE; ev_res.value = VAL_W'(CH_BANG); end
                    endcase
                end
            end
            default:
                ;
        endcase
        if (ev_wadd)
        begin
            ev_used = 1'b1;
            ev_mode = M_WORD;
            if (at_max)
            begin
                ev_fail    = 1'b1;
                ev_res.err = ERR_TOO_LONG;
            end
            else
                ev_bump = 1'b1;
        end
        if (ev_fail)
        begin
            ev_emit      = 1'b1;
            ev_res.kind  = KIND_ERROR;
            ev_res.ttype = TT_IDENT;
            ev_res.value = '0;
            ev_res.last  = 1'b0;
        end
    end

    // keyword class of the buffered word
    always_comb
    begin
        word_cls = TT_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && len_reg == LEN_W'(KW_LEN[k]))
                word_cls = KW_CLS[k];
        end
    end

    // pending token when it is ended
    always_comb
    begin
        fl_word = 1'b0;
        fl_emit = 1'b1;
        fl_fail = 1'b0;
        fl_res  = '{kind: KIND_TOKEN, ttype: TT_INT, value: '0, err: ERR_INVALID, last: 1'b1};
        case (mode_reg)
            M_ZERO:
                ;
            M_HEXX:
            begin
                fl_fail    = 1'b1;
                fl_res.err = ERR_BADHEX;
            end
            M_HEX, M_DEC:
                fl_res.value = acc_reg;
            M_WORD:
            begin
                if (dl_reg)
                begin
                    fl_fail    = 1'b1;
                    fl_res.err = ERR_DIGIT_LED;
                end
                else
                begin
                    fl_word = 1'b1;
                    fl_emit = 1'b0;
                end
            end
            M_EQ:
            begin
                fl_res.ttype = TT_ASSIGN;
                fl_res.value = VAL_W'(CH_EQ);
            end
            M_LT:
            begin
                fl_res.ttype = TT_LT;
                fl_res.value = VAL_W'(CH_LT);
            end
            M_GT:
            begin
                fl_res.ttype = TT_GT;
                fl_res.value = VAL_W'(CH_GT);
            end
            M_BANG:
            begin
                fl_res.ttype = TT_BANG;
                fl_res.value = VAL_W'(CH_BANG);
            end
            default:
                fl_emit = 1'b0;
        endcase
        if (fl_fail)
        begin
            fl_res.kind  = KIND_ERROR;
            fl_res.ttype = TT_IDENT;
            fl_res.value = '0;
            fl_res.last  = 1'b0;
        end
    end

    // byte starting a new token
    always_comb
    begin
        stt_emit = 1'b1;
        stt_fail = 1'b0;
        stt_mode = M_IDLE;
        stt_res  = '{kind: KIND_TOKEN, ttype: TT_IDENT, value: VAL_W'(c), err: ERR_INVALID,
                     last: 1'b1};
        if (is_space(c))
            stt_emit = 1'b0;
        else if (c == CH_ZERO)
        begin
            stt_emit = 1'b0;
            stt_mode = M_ZERO;
        end
        else if (c_dig)
        begin
            stt_emit = 1'b0;
            stt_mode = M_DEC;
        end
        else if (c_alp)
        begin
            stt_emit = 1'b0;
            stt_mode = M_WORD;
        end
        else
        begin
            unique case (c)
                "+":     stt_res.ttype = TT_PLUS;
                "-":     stt_res.ttype = TT_MINUS;
                "*":     stt_res.ttype = TT_STAR;
                "/":     stt_res.ttype = TT_SLASH;
                ";":     stt_res.ttype = TT_SEMI;
                "(":     stt_res.ttype = TT_LPAR;
                ")":     stt_res.ttype = TT_RPAR;
                "{":     stt_res.ttype = TT_LBRACE;
                "}":     stt_res.ttype = TT_RBRACE;
                "[":     stt_res.ttype = TT_LBRACK;
                "]":     stt_res.ttype = TT_RBRACK;
                ",":     stt_res.ttype = TT_COMMA;
                CH_EQ:   begin stt_emit = 1'b0; stt_mode = M_EQ; end
                CH_LT:   begin stt_emit = 1'b0; stt_mode = M_LT; end
                CH_GT:   begin stt_emit = 1'b0; stt_mode = M_GT; end
                CH_BANG: begin stt_emit = 1'b0; stt_mode = M_BANG; end
                default:
                begin
                    stt_fail      = 1'b1;
                    stt_res.kind  = KIND_ERROR;
                    stt_res.value = '0;
                    stt_res.last  = 1'b0;
                end
            endcase
        end
    end

    assign word_last = (rd_idx_reg + LEN_W'(1)) == len_reg;
    assign wd_res    = '{kind: KIND_TOKEN, ttype: word_cls, value: VAL_W'(mem_q_reg),
                         err: ERR_INVALID, last: word_last};

    assign st.eoi        = eoi_reg;
    assign st.used       = ev_used;
    assign st.eval_emit  = ev_emit;
    assign st.eval_fail  = ev_fail;
    assign st.flush_word = fl_word;
    assign st.flush_emit = fl_emit;
    assign st.flush_fail = fl_fail;
    assign st.start_emit = stt_emit || stt_fail;
    assign st.start_fail = stt_fail;
    assign st.word_last  = word_last;
    assign st.out_free   = !out_valid_reg || out_ready;

    // result selection
    always_comb
    begin
        emit      = 1'b0;
        emit_res  = fl_res;
        emit_line = tok_line_reg;
        emit_col  = tok_col_reg;
        if (cmd.eval && ev_emit)
        begin
            emit     = 1'b1;
            emit_res = ev_res;
        end
        else if (cmd.flush)
            emit = 1'b1;
        else if (cmd.word_emit)
        begin
            emit     = 1'b1;
            emit_res = wd_res;
        end
        else if (cmd.start && (stt_emit || stt_fail))
        begin
            emit      = 1'b1;
            emit_res  = stt_res;
            emit_line = lat_line_reg;
            emit_col  = lat_col_reg;
        end
        else if (cmd.end_emit)
        begin
            emit      = 1'b1;
            emit_res  = '{kind: KIND_END, ttype: TT_IDENT, value: '0, err: ERR_INVALID,
                          last: 1'b0};
            emit_line = '0;
            emit_col  = '0;
        end
    end

    // scanner state update
    always_comb
    begin
        mode_next     = mode_reg;
        len_next      = len_reg;
        dl_next       = dl_reg;
        acc_next      = acc_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        cand_next     = cand_reg;
        rd_idx_next   = rd_idx_reg;
        wr_en         = 1'b0;
        wr_addr       = len_reg[IDX_W-1:0];
        if (cmd.accept && !in_eoi)
        begin
            if (in_byte == CH_LF)
            begin
                cur_line_next = (cur_line_reg != '1) ? cur_line_reg + 1'b1 : cur_line_reg;
                cur_col_next  = '0;
            end
            else
                cur_col_next = (cur_col_reg != '1) ? cur_col_reg + 1'b1 : cur_col_reg;
        end
        if (cmd.eval)
        begin
            mode_next = ev_mode;
            if (ev_bump && len_reg != '1)
                len_next = len_reg + 1'b1;
            if (ev_acc)
                acc_next = acc_sat;
            if (ev_wadd && !at_max && !dl_reg)
            begin
                wr_en = 1'b1;
                for (int k = 0; k < KW_NUM; k++)
                    cand_next[k] = cand_reg[k] && (len_reg < LEN_W'(KW_LEN[k])) &&
                                   kw_char(k, len_reg[2:0]) == c;
            end
        end
        if (cmd.flush)
            mode_next = M_IDLE;
        if (cmd.word_start)
            rd_idx_next = '0;
        if (cmd.word_emit)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
            if (word_last)
                mode_next = M_IDLE;
        end
        if (cmd.start)
        begin
            tok_line_next = lat_line_reg;
            tok_col_next  = lat_col_reg;
            len_next      = LEN_W'(1);
            dl_next       = (stt_mode == M_ZERO) || (stt_mode == M_DEC);
            acc_next      = (stt_mode == M_DEC) ? VAL_W'(hex_value(c)) : '0;
            mode_next     = stt_mode;
            if (stt_mode == M_WORD)
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                for (int k = 0; k < KW_NUM; k++)
                    cand_next[k] = kw_char(k, 3'd0) == c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= c;
        mem_q_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg     <= in_byte;
            lat_line_reg <= cur_line_reg;
            lat_col_reg  <= cur_col_reg;
        end
        if (emit)
        begin
            out_res_reg  <= emit_res;
            out_line_reg <= emit_line;
            out_col_reg  <= emit_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            len_reg       <= '0;
            dl_reg        <= 1'b0;
            acc_reg       <= '0;
            tok_line_reg  <= '0;
            tok_col_reg   <= '0;
            cur_line_reg  <= '0;
            cur_col_reg   <= '0;
            cand_reg      <= '0;
            rd_idx_reg    <= '0;
            eoi_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            dl_reg        <= dl_next;
            acc_reg       <= acc_next;
            tok_line_reg  <= tok_line_next;
            tok_col_reg   <= tok_col_next;
            cur_line_reg  <= cur_line_next;
            cur_col_reg   <= cur_col_next;
            cand_reg      <= cand_next;
            rd_idx_reg    <= rd_idx_next;
            if (cmd.accept)
                eoi_reg <= in_eoi;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_line  = out_line_reg;
    assign out_col   = out_col_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result overwrites a waiting item");
    a_replay_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.word_emit |-> rd_idx_reg < len_reg)
        else $error("word replay past buffered length");
    a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_WORD && !dl_reg) |-> (len_reg <= LEN_MAX && len_reg != '0))
        else $error("word length out of range");

endmodule

[sv/source_token_scanner_unit.sv]
// Streaming lexer for a small C-like language.
// Input channel s_axis: one source byte per item in tdata; tlast marks the
// end of input (its tdata is ignored). Output channel m_axis: one result per
// item, result kind in tuser (token, error, end), last character of a token
// on tlast.
// The block takes no new byte until it is through with the last one. A byte
// that ends a token is followed by the output of that token; a word token
// replays its buffered characters from the word memory one at a time,
// each read through the registered read port of that memory.
// The output is a single register: the block keeps working while a result
// waits there and holds only when the next result is ready and the register
// is still full, so receiver stalls back up to s_axis_tready.
// After reset the block is idle at line 0, column 0, ready at once. After an
// error or the end result it emits nothing until the next reset; input items
// are still taken and dropped.
module source_token_scanner_unit #(
    parameter int MAX_WORD_LEN = sts_pkg::MAX_WORD_LEN_DEF,
    parameter int POS_BITS     = sts_pkg::POS_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // source_byte
    input  logic                                 s_axis_tlast,  // end_of_input
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // token_type, token_value, start_line, start_column, error_code, zero fill
    output logic [((2*POS_BITS+40+7)/8)*8-1:0]   m_axis_tdata,
    output logic [1:0]                           m_axis_tuser,  // result_kind
    output logic                                 m_axis_tlast   // last_of_token
);
    import sts_pkg::*;

    localparam int TDATA_W = ((2 * POS_BITS + 40 + 7) / 8) * 8;

    cmd_t                cmd;
    status_t             st;
    res_t                res;
    logic [POS_BITS-1:0] line, col;

    sts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sts_datapath #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .POS_BITS     (POS_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_byte   (s_axis_tdata),
        .in_eoi    (s_axis_tlast),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (res),
        .out_line  (line),
        .out_col   (col)
    );

    assign m_axis_tdata = TDATA_W'({res.err, col, line, res.value, res.ttype});
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

[tb/sv/source_token_scanner_unit_tb.sv]
module source_token_scanner_unit_tb;
    import sts_pkg::*;

    localparam int WORD_MAX = 32;
    localparam logic [15:0] POS_SAT = 16'hFFFF;
    localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;
    localparam logic [2:0] NO_ERR = 3'd0;
    localparam logic [5:0] NO_TYPE = 6'd0;

    typedef enum {
        LX_IDLE, LX_ZERO, LX_HEXX, LX_HEX, LX_DEC, LX_WORD, LX_EQ, LX_LT, LX_GT, LX_BANG,
        LX_HALT
    } lex_state_t;

    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  ttype;
        logic [30:0] value;
        logic [15:0] line;
        logic [15:0] col;
        logic [2:0]  err;
        logic        last;
    } lex_result_t;

    typedef struct {
        string       src;
        bit          has_exp;
        lex_result_t exp;
    } text_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    source_token_scanner_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lex_state_t  lx_state;
    logic [7:0]  word_buf [64];
    int unsigned word_len;
    bit          word_digit_led;
    longint unsigned num_acc;
    logic [15:0] tok_line, tok_col, cur_line, cur_col;

    lex_result_t step_out[$];
    lex_result_t expected_tokens[$];
    int  fail_cnt;
    bit  calm;

    string       kw_words [19] = '{"scan", "void", "int", "char", "double", "struct", "if",
                                   "else", "switch", "case", "default", "while", "for", "do",
                                   "return", "break", "continue", "const", "print"};
    int unsigned kw_class [19] = '{2, 3, 3, 3, 3, 4, 5, 6, 7, 7, 7, 8, 9, 10, 11, 12, 13,
                                   14, 15};

    function automatic bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_ch(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit hexletter_ch(logic [7:0] c);
        return (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic int unsigned nibble_of(logic [7:0] c);
        if (digit_ch(c))
            return c - 48;
        if (c >= "a")
            return c - 87;
        return c - 55;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [5:0] ttype,
                                       logic [30:0] value, logic [15:0] line,
                                       logic [15:0] col, logic [2:0] err, logic last);
        lex_result_t r;
        r = '{kind, ttype, value, line, col, err, last};
        step_out.push_back(r);
    endfunction

    function automatic void lex_fail(logic [2:0] code);
        lx_state = LX_HALT;
        add_result(KIND_ERROR, NO_TYPE, 0, tok_line, tok_col, code, 1'b0);
    endfunction

    function automatic void lex_single(logic [5:0] ttype, logic [30:0] value);
        lx_state = LX_IDLE;
        add_result(KIND_TOKEN, ttype, value, tok_line, tok_col, NO_ERR, 1'b1);
    endfunction

    function automatic void grow_len();
        if (word_len < 63)
            word_len++;
    endfunction

    function automatic void accumulate(int unsigned base, int unsigned digit);
        longint unsigned v;
        v = num_acc * base + digit;
        num_acc = (v > INT_SAT) ? INT_SAT : v;
    endfunction

    function automatic void word_append(logic [7:0] c);
        lx_state = LX_WORD;
        if (word_len >= WORD_MAX)
        begin
            lex_fail(ERR_TOO_LONG);
            return;
        end
        if (!word_digit_led)
            word_buf[word_len] = c;
        grow_len();
    endfunction

    function automatic void word_release();
        int unsigned cls;
        bit          hit;
        cls = 0;
        if (word_digit_led)
        begin
            lex_fail(ERR_DIGIT_LED);
            return;
        end
        for (int k = 0; k < 19 && cls == 0; k++)
        begin
            hit = kw_words[k].len() == word_len;
            for (int i = 0; i < word_len && hit; i++)
                if (kw_words[k][i] != word_buf[i])
                    hit = 0;
            if (hit)
                cls = kw_class[k];
        end
        for (int unsigned i = 0; i < word_len; i++)
            add_result(KIND_TOKEN, 6'(cls), 31'(word_buf[i]), tok_line, tok_col, NO_ERR,
                       i + 1 == word_len);
        lx_state = LX_IDLE;
    endfunction

    function automatic void flush_pending();
        case (lx_state)
            LX_ZERO: lex_single(TT_INT, 0);
            LX_HEXX: lex_fail(ERR_BADHEX);
            LX_HEX, LX_DEC: lex_single(TT_INT, 31'(num_acc));
            LX_WORD: word_release();
            LX_EQ:   lex_single(TT_ASSIGN, 31'(CH_EQ));
            LX_LT:   lex_single(TT_LT, 31'(CH_LT));
            LX_GT:   lex_single(TT_GT, 31'(CH_GT));
            LX_BANG: lex_single(TT_BANG, 31'(CH_BANG));
            default: ;
        endcase
    endfunction

    function automatic void open_token(logic [7:0] c, logic [15:0] line, logic [15:0] col);
        tok_line = line;
        tok_col = col;
        word_len = 1;
        word_digit_led = 0;
        num_acc = 0;
        if ((c >= 9 && c <= 13) || c == CH_SPACE)
            return;
        if (c == CH_ZERO)
        begin
            lx_state = LX_ZERO;
            word_digit_led = 1;
        end
        else if (digit_ch(c))
        begin
            lx_state = LX_DEC;
            word_digit_led = 1;
            num_acc = c - 48;
        end
        else if (letter_ch(c))
        begin
            lx_state = LX_WORD;
            word_buf[0] = c;
        end
        else
        begin
            case (c)
                "+": lex_single(TT_PLUS, 31'(c));
                "-": lex_single(TT_MINUS, 31'(c));
                "*": lex_single(TT_STAR, 31'(c));
                "/": lex_single(TT_SLASH, 31'(c));
                ";": lex_single(TT_SEMI, 31'(c));
                "(": lex_single(TT_LPAR, 31'(c));
                ")": lex_single(TT_RPAR, 31'(c));
                "{": lex_single(TT_LBRACE, 31'(c));
                "}": lex_single(TT_RBRACE, 31'(c));
                "[": lex_single(TT_LBRACK, 31'(c));
                "]": lex_single(TT_RBRACK, 31'(c));
                ",": lex_single(TT_COMMA, 31'(c));
                "=": lx_state = LX_EQ;
                "<": lx_state = LX_LT;
                ">": lx_state = LX_GT;
                "!": lx_state = LX_BANG;
                default: lex_fail(ERR_INVALID);
            endcase
        end
    endfunction

    // results caused by one source item, left in step_out
    function automatic void lex_byte(logic [7:0] c, logic eoi);
        logic [15:0] line, col;
        bit          used;
        step_out.delete();
        used = 0;
        if (lx_state == LX_HALT)
            return;
        if (eoi)
        begin
            flush_pending();
            if (lx_state == LX_HALT)
                return;
            lx_state = LX_HALT;
            add_result(KIND_END, NO_TYPE, 0, 0, 0, NO_ERR, 1'b0);
            return;
        end
        line = cur_line;
        col = cur_col;
        if (c == CH_LF)
        begin
            cur_line = (line < POS_SAT) ? line + 1 : POS_SAT;
            cur_col = 0;
        end
        else
            cur_col = (col < POS_SAT) ? col + 1 : POS_SAT;
        case (lx_state)
            LX_ZERO:
            begin
                if (c == "x" || c == "X")
                begin
                    lx_state = LX_HEXX;
                    grow_len();
                    used = 1;
                end
                else if (digit_ch(c))
                begin
                    lex_fail(ERR_LEADZERO);
                    return;
                end
                else if (letter_ch(c))
                begin
                    word_append(c);
                    used = 1;
                end
            end
            LX_HEXX:
            begin
                if (digit_ch(c) || hexletter_ch(c))
                begin
                    lx_state = LX_HEX;
                    grow_len();
                    accumulate(16, nibble_of(c));
                    used = 1;
                end
                else if (letter_ch(c))
                begin
                    word_append(c);
                    used = 1;
                end
                else
                begin
                    lex_fail(ERR_BADHEX);
                    return;
                end
            end
            LX_HEX, LX_DEC:
            begin
                if (lx_state == LX_HEX && (digit_ch(c) || hexletter_ch(c)))
                begin
                    grow_len();
                    accumulate(16, nibble_of(c));
                    used = 1;
                end
                else if (lx_state == LX_DEC && digit_ch(c))
                begin
                    grow_len();
                    accumulate(10, c - 48);
                    used = 1;
                end
                else if (letter_ch(c))
                begin
                    word_append(c);
                    used = 1;
                end
            end
            LX_WORD:
                if (digit_ch(c) || letter_ch(c))
                begin
                    word_append(c);
                    used = 1;
                end
            LX_EQ, LX_LT, LX_GT, LX_BANG:
                if (c == CH_EQ)
                begin
                    case (lx_state)
                        LX_EQ:   lex_single(TT_EQEQ, 31'(CH_EQ));
                        LX_LT:   lex_single(TT_LE, 31'(CH_LT));
                        LX_GT:   lex_single(TT_GE, 31'(CH_GT));
                        default: lex_single(TT_NE, 31'(CH_BANG));
                    endcase
                    used = 1;
                end
            default: ;
        endcase
        if (used)
            return;
        flush_pending();
        if (lx_state == LX_HALT)
            return;
        lx_state = LX_IDLE;
        open_token(c, line, col);
    endfunction

    function automatic void compare_result(lex_result_t e, lex_result_t a);
        bit bad;
        bad = 0;
        if (a.kind !== e.kind)
        begin
            $error("result_kind: expected %0d, actual %0d", e.kind, a.kind);
            bad = 1;
        end
        if (a.ttype !== e.ttype)
        begin
            $error("token_type: expected %0d, actual %0d", e.ttype, a.ttype);
            bad = 1;
        end
        if (a.value !== e.value)
        begin
            $error("token_value: expected %0d, actual %0d", e.value, a.value);
            bad = 1;
        end
        if (a.line !== e.line)
        begin
            $error("start_line: expected %0d, actual %0d", e.line, a.line);
            bad = 1;
        end
        if (a.col !== e.col)
        begin
            $error("start_column: expected %0d, actual %0d", e.col, a.col);
            bad = 1;
        end
        if (a.err !== e.err)
        begin
            $error("error_code: expected %0d, actual %0d", e.err, a.err);
            bad = 1;
        end
        if (a.last !== e.last)
        begin
            $error("last_of_token: expected %0d, actual %0d", e.last, a.last);
            bad = 1;
        end
        if (bad)
            fail_cnt++;
    endfunction

    task automatic send_byte(logic [7:0] b, logic eoi);
        while (!calm && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eoi;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        lex_byte(b, eoi);
        foreach (step_out[i])
            expected_tokens.push_back(step_out[i]);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic string rand_chars(string pool, int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(pool[$urandom_range(pool.len() - 1)])};
        return s;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        lex_result_t act;
        if (m_axis_tvalid && m_axis_tready)
        begin
            act = '{m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[36:6], m_axis_tdata[52:37],
                    m_axis_tdata[68:53], m_axis_tdata[71:69], m_axis_tlast};
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: kind %0d type %0d", act.kind, act.ttype);
                fail_cnt++;
            end
            else
                compare_result(expected_tokens.pop_front(), act);
        end
        if (rst_n)
            m_axis_tready <= calm || $urandom_range(99) >= 22;
    end

    initial
    begin
        text_row_t   rows[$];
        string       pool_alpha, pool_alnum, pool_hex, t;
        int unsigned pick, waited;
        bit          prev_alnum, cur_alnum;
        string       ops [20] = '{"+", "-", "*", "/", "=", "==", ";", "(", ")", "<", "<=",
                                  ">", ">=", "{", "}", "[", "]", "!", "!=", ","};

        pool_alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
        pool_alnum = {pool_alpha, "0123456789"};
        pool_hex = "0123456789abcdefABCDEF";
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        fail_cnt = 0;
        calm = 0;
        lx_state = LX_IDLE;
        word_len = 0;
        word_digit_led = 0;
        num_acc = 0;
        tok_line = 0;
        tok_col = 0;
        cur_line = 0;
        cur_col = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{"+", 1, '{KIND_TOKEN, TT_PLUS, 31'd43, 16'd0, 16'd0, NO_ERR, 1'b1}});
        rows.push_back('{"2147483648 ", 1,
                         '{KIND_TOKEN, TT_INT, INT_SAT, 16'd0, 16'd1, NO_ERR, 1'b1}});
        rows.push_back('{"0x7fffffffff ", 1,
                         '{KIND_TOKEN, TT_INT, INT_SAT, 16'd0, 16'd12, NO_ERR, 1'b1}});
        rows.push_back('{"0 9 1234567890\t", 0, '{default: '0}});
        rows.push_back('{"== =a <=< >=> !=! ", 0, '{default: '0}});
        rows.push_back('{"-*/;(){}[],\n", 0, '{default: '0}});
        rows.push_back('{"scan void int char double struct if else switch case ", 0,
                         '{default: '0}});
        rows.push_back('{"default while for do return break continue const print\n", 0,
                         '{default: '0}});
        rows.push_back('{"abcdefghijklmnopqrstuvwxyzABCDEF Z9 x ", 0, '{default: '0}});
        rows.push_back('{"0xAbC9 0XF\x0b\x0c\r 0x0 ", 0, '{default: '0}});
        foreach (rows[r])
        begin
            send_text(rows[r].src);
            if (rows[r].has_exp)
                compare_result(rows[r].exp, step_out[0]);
        end

        // hold off until the block has drained
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);

        prev_alnum = 0;
        for (int n = 0; n < 130; n++)
        begin
            calm = (n >= 40 && n < 70);
            pick = $urandom_range(9);
            cur_alnum = 1;
            case (pick)
                0, 1: t = {rand_chars(pool_alpha, 1), rand_chars(pool_alnum,
                           ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6))};
                2:    t = kw_words[$urandom_range(18)];
                3:    t = ($urandom_range(4) == 0) ? "0" :
                          {rand_chars("123456789", 1), rand_chars("0123456789",
                                                                $urandom_range(11))};
                4:    t = {($urandom_range(1) != 0) ? "0x" : "0X",
                           rand_chars(pool_hex, $urandom_range(1, 10))};
                5, 6, 7:
                begin
                    t = ops[$urandom_range(19)];
                    cur_alnum = 0;
                end
                default:
                begin
                    t = rand_chars(" \t\n\n\r", $urandom_range(1, 3));
                    cur_alnum = 0;
                end
            endcase
            if (prev_alnum && cur_alnum)
                send_byte(CH_SPACE, 1'b0);
            send_text(t);
            prev_alnum = cur_alnum;
        end

        // one way out of the scanner, then ignored traffic
        send_byte(CH_SPACE, 1'b0);
        case ($urandom_range(5))
            0: send_byte(8'($urandom), 1'b1);
            1: send_byte(($urandom_range(1) != 0) ? 8'($urandom_range(127, 255)) :
                         8'($urandom_range(0, 8)), 1'b0);
            2: send_text("05");
            3:
            begin
                send_text("0x");
                send_byte(CH_SPACE, $urandom_range(1));
            end
            4: send_text("12ab ");
            default: send_text(rand_chars(pool_alpha, 33));
        endcase
        for (int i = 0; i < 12; i++)
            send_byte(8'($urandom), $urandom_range(1));
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (expected_tokens.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (fail_cnt == 0 && expected_tokens.size() == 0)
            $display("RESULT: OK");
        else
        begin
            if (expected_tokens.size() != 0)
                $error("%0d expected results never arrived", expected_tokens.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
